>>> sv/tlf_pkg.sv
// tlf_pkg: shared types, byte codes and column arithmetic for the line folder.
// Used by tlf_decide and text_line_folder; depends on nothing.
package tlf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned ColW    = 17;
  localparam int unsigned TabW    = 8;
  localparam int unsigned TabBits = $clog2(TabW);

  localparam logic [WidthW-1:0] WidthReset = WidthW'(1000);
  localparam logic [ColW-1:0]   ColMax     = {ColW{1'b1}};

  localparam logic [ByteW-1:0] ChBs  = 8'd8;
  localparam logic [ByteW-1:0] ChTab = 8'd9;
  localparam logic [ByteW-1:0] ChNl  = 8'd10;
  localparam logic [ByteW-1:0] ChCr  = 8'd13;

  // Phase of the beat run for the held byte
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_CR    = 3'b010,
    PH_BYTE  = 3'b100
  } phase_t;

  // One step of the sequencer: the beat to emit and the state to move to
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             done;
    phase_t           phase_nxt;
    logic [ColW-1:0]  col_nxt;
    logic             has_nxt;
  } step_t;

  // Column after placing a byte, saturating at the top of the range
  function automatic logic [ColW-1:0] next_col(input logic [ColW-1:0]  col,
                                               input logic [ByteW-1:0] ch);
    logic [ColW:0] sum;
    logic [ColW-1:0] res;
    sum = '0;
    res = '0;
    if (ch == ChBs) begin
      res = (col != '0) ? col - ColW'(1) : '0;
    end else if (ch == ChCr) begin
      res = '0;
    end else begin
      if (ch == ChTab) begin
        sum = {1'b0, col | ColW'(TabW - 1)} + (ColW+1)'(1);
      end else begin
        sum = {1'b0, col} + (ColW+1)'(1);
      end
      res = sum[ColW] ? ColMax : sum[ColW-1:0];
    end
    return res;
  endfunction

endpackage

>>> sv/tlf_decide.sv
// tlf_decide: combinational step logic; picks the next beat for the held byte.
// Depends on tlf_pkg.
module tlf_decide (
  input  logic [tlf_pkg::ByteW-1:0]  ch,
  input  tlf_pkg::phase_t            phase,
  input  logic [tlf_pkg::ColW-1:0]   col,
  input  logic                       has_bytes,
  input  logic [tlf_pkg::WidthW-1:0] line_width,
  output tlf_pkg::step_t             step
);

  logic [tlf_pkg::ColW-1:0] col_adv;
  logic [tlf_pkg::ColW-1:0] col_fresh;
  logic                     brk;

  assign col_adv   = tlf_pkg::next_col(col, ch);
  assign col_fresh = tlf_pkg::next_col('0, ch);
  // break only when the line already holds bytes
  assign brk       = (col_adv > {1'b0, line_width}) && has_bytes;

  always_comb begin
    step.out_byte  = ch;
    step.last      = 1'b1;
    step.done      = 1'b1;
    step.phase_nxt = tlf_pkg::PH_FIRST;
    step.col_nxt   = col_adv;
    step.has_nxt   = 1'b1;
    unique case (phase)
      tlf_pkg::PH_FIRST: begin
        if (ch == tlf_pkg::ChNl) begin
          step.col_nxt = '0;
          step.has_nxt = 1'b0;
        end else if (brk) begin
          // inserted newline; state holds until the byte itself goes out
          step.out_byte  = tlf_pkg::ChNl;
          step.last      = 1'b0;
          step.done      = 1'b0;
          step.phase_nxt = tlf_pkg::PH_CR;
          step.col_nxt   = col;
          step.has_nxt   = has_bytes;
        end
      end
      tlf_pkg::PH_CR: begin
        step.out_byte  = tlf_pkg::ChCr;
        step.last      = 1'b0;
        step.done      = 1'b0;
        step.phase_nxt = tlf_pkg::PH_BYTE;
        step.col_nxt   = col;
        step.has_nxt   = has_bytes;
      end
      tlf_pkg::PH_BYTE: begin
        // byte on the fresh line, emitted even if still too wide
        step.col_nxt = col_fresh;
      end
      default: begin
        step.out_byte  = ch;
      end
    endcase
  end

endmodule

>>> sv/text_line_folder.sv
// text_line_folder: top level of the line folder; input, state and output registers.
// Depends on tlf_pkg and tlf_decide.
//
// Folds a byte stream into lines no wider than cfg line_width columns unless one byte
// alone is wider. A byte is taken into an input register and one result beat is produced
// per cycle into an output register while out_stall is low, so ordinary bytes stream
// at one per cycle. A byte that forces a break yields three beats (newline, carriage
// return, byte) and holds the input register until the byte goes out. last_of_run
// marks the final beat of each byte. The width register may only be written while idle.
module text_line_folder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tlf_pkg::WidthW-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tlf_pkg::ByteW-1:0]  in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tlf_pkg::ByteW-1:0]  out_byte,
  output logic                       out_last_of_run
);

  logic [tlf_pkg::WidthW-1:0] width_r;
  logic [tlf_pkg::ByteW-1:0]  in_byte_r;
  logic                       in_vld_r, in_vld_nxt;
  tlf_pkg::phase_t            phase_r, phase_nxt;
  logic [tlf_pkg::ColW-1:0]   col_r, col_nxt;
  logic                       has_r, has_nxt;
  logic [tlf_pkg::ByteW-1:0]  out_byte_r;
  logic                       out_last_r;
  logic                       out_vld_r, out_vld_nxt;
  tlf_pkg::step_t             step;
  logic                       out_load;
  logic                       fire;
  logic                       consume;
  logic                       take;

  tlf_decide u_decide (
    .ch         (in_byte_r),
    .phase      (phase_r),
    .col        (col_r),
    .has_bytes  (has_r),
    .line_width (width_r),
    .step       (step)
  );

  // handshake glue
  assign out_load = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_load;
  assign consume  = fire && step.done;
  assign in_stall = in_vld_r && !consume;
  assign take     = in_valid && !in_stall;

  // next state
  always_comb begin
    in_vld_nxt  = take ? 1'b1 : (consume ? 1'b0 : in_vld_r);
    phase_nxt   = fire ? step.phase_nxt : phase_r;
    col_nxt     = fire ? step.col_nxt : col_r;
    has_nxt     = fire ? step.has_nxt : has_r;
    out_vld_nxt = fire ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= tlf_pkg::WidthReset;
      in_vld_r  <= 1'b0;
      phase_r   <= tlf_pkg::PH_FIRST;
      col_r     <= '0;
      has_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      in_vld_r  <= in_vld_nxt;
      phase_r   <= phase_nxt;
      col_r     <= col_nxt;
      has_r     <= has_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r <= in_byte;
    end
    if (fire) begin
      out_byte_r <= step.out_byte;
      out_last_r <= step.last;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule
